// File: design/todc_pkg.sv
// Shared types for the time-of-day counter: counter state, item and cfg words, result word.
// No dependencies; compiled first.
package todc_pkg;

	localparam int unsigned SecPerMin  = 60;
	localparam int unsigned MinPerHour = 60;
	localparam int unsigned HoursPerDay = 24;
	localparam int unsigned HalfDay    = 12;
	localparam int unsigned DecRadix   = 10;
	localparam int unsigned TensLimit  = 6;

	typedef struct packed {
		logic [5:0] sec_count;
		logic [5:0] min_count;
		logic [4:0] hour24_count;
		logic [3:0] hour12_count;
		logic       pm_state;
		logic [3:0] sec_ones;
		logic [2:0] sec_tens;
		logic [3:0] min_ones;
		logic [2:0] min_tens;
		logic [3:0] h12_ones;
		logic       h12_tens;
		logic [3:0] h24_ones;
		logic [1:0] h24_tens;
	} time_t;

	typedef struct packed {
		logic tick;
	} item_t;

	typedef struct packed {
		logic paused;
	} cfg_t;

	typedef struct packed {
		logic [5:0] seconds_bin;
		logic [5:0] minutes_bin;
		logic [4:0] hours_24_bin;
		logic [3:0] hours_12_bin;
		logic       pm_flag;
		logic [6:0] seconds_bcd;
		logic [6:0] minutes_bcd;
		logic [4:0] hours_12_bcd;
		logic [5:0] hours_24_bcd;
	} result_t;

endpackage

// File: design/todc_chan_if.sv
// Valid/ready channel carrying one payload word per handshake.
// Depends on nothing; the payload type is given per instance.
interface todc_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/todc_time_regs.sv
// Time-of-day state registers, pause register and next-time logic.
// Depends on todc_pkg.
module todc_time_regs (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_paused,
	input  logic            advance_en,
	input  logic            tick,
	output todc_pkg::time_t time_nxt
);
	import todc_pkg::*;

	time_t      time_q;
	logic       paused_q;
	logic       step;
	logic [6:0] sec_sum, min_sum;
	logic [4:0] so_sum, mo_sum, h12o_sum, h24o_sum;
	logic [3:0] st_sum, mt_sum;
	logic [5:0] h24_sum;
	logic       sec_wrap, min_wrap;
	logic [3:0] so_n, mo_n, h12o_n, h24o_n;
	logic [2:0] st_n, mt_n;
	logic       h12t_n;
	logic [1:0] h24t_n;
	logic [4:0] h24c_n;
	logic [3:0] h12c_n;
	logic       pm_n;

	always_comb begin
		step     = tick && !paused_q;
		sec_sum  = {1'b0, time_q.sec_count} + 7'd1;
		min_sum  = {1'b0, time_q.min_count} + 7'd1;
		so_sum   = {1'b0, time_q.sec_ones} + 5'd1;
		mo_sum   = {1'b0, time_q.min_ones} + 5'd1;
		st_sum   = {1'b0, time_q.sec_tens} + 4'd1;
		mt_sum   = {1'b0, time_q.min_tens} + 4'd1;
		h12o_sum = {1'b0, time_q.h12_ones} + 5'd1;
		h24o_sum = {1'b0, time_q.h24_ones} + 5'd1;
		h24_sum  = {1'b0, time_q.hour24_count} + 6'd1;
		sec_wrap = sec_sum >= 7'(SecPerMin);
		min_wrap = min_sum >= 7'(MinPerHour);

		so_n = time_q.sec_ones;
		st_n = time_q.sec_tens;
		time_nxt = time_q;
		if (step) begin
			time_nxt.sec_count = sec_wrap ? 6'd0 : sec_sum[5:0];
			if (so_sum >= 5'(DecRadix)) begin
				so_n = 4'd0;
				st_n = (st_sum >= 4'(TensLimit)) ? 3'd0 : st_sum[2:0];
			end else begin
				so_n = so_sum[3:0];
				st_n = time_q.sec_tens;
			end
			time_nxt.sec_ones = so_n;
			time_nxt.sec_tens = st_n;
		end

		mo_n = time_q.min_ones;
		mt_n = time_q.min_tens;
		if (mo_sum >= 5'(DecRadix)) begin
			mo_n = 4'd0;
			mt_n = (mt_sum >= 4'(TensLimit)) ? 3'd0 : mt_sum[2:0];
		end else begin
			mo_n = mo_sum[3:0];
		end
		if (step && sec_wrap) begin
			time_nxt.min_count = min_wrap ? 6'd0 : min_sum[5:0];
			time_nxt.min_ones  = mo_n;
			time_nxt.min_tens  = mt_n;
		end

		h24c_n = (h24_sum >= 6'(HoursPerDay)) ? 5'd0 : h24_sum[4:0];
		if (h24c_n == 5'd0) begin
			h12c_n = 4'(HalfDay);
			pm_n   = 1'b0;
		end else if (h24c_n == 5'(HalfDay)) begin
			h12c_n = 4'(HalfDay);
			pm_n   = 1'b1;
		end else if (h24c_n > 5'(HalfDay)) begin
			h12c_n = 4'(h24c_n - 5'(HalfDay));
			pm_n   = 1'b1;
		end else begin
			h12c_n = h24c_n[3:0];
			pm_n   = 1'b0;
		end

		if (time_q.h12_tens && time_q.h12_ones >= 4'd2) begin
			h12t_n = 1'b0;
			h12o_n = 4'd1;
		end else if (h12o_sum >= 5'(DecRadix)) begin
			h12t_n = ~time_q.h12_tens;
			h12o_n = 4'd0;
		end else begin
			h12t_n = time_q.h12_tens;
			h12o_n = h12o_sum[3:0];
		end

		if (h24o_sum >= 5'(DecRadix)) begin
			h24o_n = 4'd0;
			h24t_n = time_q.h24_tens + 2'd1;
		end else begin
			h24o_n = h24o_sum[3:0];
			h24t_n = time_q.h24_tens;
		end
		if (h24t_n >= 2'd2 && h24o_n >= 4'd4) begin
			h24t_n = 2'd0;
			h24o_n = 4'd0;
		end

		if (step && sec_wrap && min_wrap) begin
			time_nxt.hour24_count = h24c_n;
			time_nxt.hour12_count = h12c_n;
			time_nxt.pm_state     = pm_n;
			time_nxt.h12_ones     = h12o_n;
			time_nxt.h12_tens     = h12t_n;
			time_nxt.h24_ones     = h24o_n;
			time_nxt.h24_tens     = h24t_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paused_q <= 1'b0;
			time_q   <= '{
				sec_count: 6'd0, min_count: 6'd0, hour24_count: 5'd0,
				hour12_count: 4'(HalfDay), pm_state: 1'b0,
				sec_ones: 4'd0, sec_tens: 3'd0, min_ones: 4'd0, min_tens: 3'd0,
				h12_ones: 4'd2, h12_tens: 1'b1, h24_ones: 4'd0, h24_tens: 2'd0
			};
		end else begin
			if (cfg_we) begin
				paused_q <= cfg_paused;
			end
			if (advance_en) begin
				time_q <= time_nxt;
			end
		end
	end

endmodule

// File: design/todc_out_stage.sv
// Result register: packs the time into the result word and holds it
// until taken. Depends on todc_pkg.
module todc_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  todc_pkg::time_t   time_in,
	input  logic              out_ready,
	output logic              out_valid,
	output todc_pkg::result_t out_data,
	output logic              can_load
);
	import todc_pkg::*;

	logic    valid_q;
	result_t data_q;
	result_t packed_word;

	always_comb begin
		packed_word.seconds_bin  = time_in.sec_count;
		packed_word.minutes_bin  = time_in.min_count;
		packed_word.hours_24_bin = time_in.hour24_count;
		packed_word.hours_12_bin = time_in.hour12_count;
		packed_word.pm_flag      = time_in.pm_state;
		packed_word.seconds_bcd  = {time_in.sec_tens, time_in.sec_ones};
		packed_word.minutes_bcd  = {time_in.min_tens, time_in.min_ones};
		packed_word.hours_12_bcd = {time_in.h12_tens, time_in.h12_ones};
		packed_word.hours_24_bcd = {time_in.h24_tens, time_in.h24_ones};
	end

	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= packed_word;
		end
	end

endmodule

// File: design/time_of_day_counter_bcd_12_24_core.sv
// Top level of the time-of-day counter, binary and BCD, 12 and 24 hour.
// Depends on todc_pkg, todc_chan_if, todc_time_regs, todc_out_stage.
//
// Channels: item (sink) carries one tick word; result (source) carries the
// time after that word in binary, packed BCD, 24-hour and 12-hour with PM.
// cfg (sink) writes the paused bit; it is always ready.
// Every accepted item gives exactly one result word.
// Latency: the result is valid the cycle after the item is accepted.
// Throughput: one item per cycle; the time registers update at accept and
// the result register is the only stage, so item ready stays high whenever
// the result register is empty or being drained in the same cycle.
// Stall: while result is held (valid without ready) item ready drops and
// the time holds; nothing is lost or repeated.
// Reset: arst_n clears the result valid flag, clears paused and sets the
// time to 12:00:00 AM (24-hour 00:00:00).
module time_of_day_counter_bcd_12_24_core (
	input logic clk,
	input logic arst_n,
	todc_chan_if.sink   item,
	todc_chan_if.sink   cfg,
	todc_chan_if.source result
);
	import todc_pkg::*;

	logic  accept;
	logic  can_load;
	time_t time_nxt;

	assign item.ready = can_load;
	assign cfg.ready  = 1'b1;
	assign accept     = item.valid && can_load;

	todc_time_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg.valid),
		.cfg_paused (cfg.data.paused),
		.advance_en (accept),
		.tick       (item.data.tick),
		.time_nxt   (time_nxt)
	);

	todc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.time_in   (time_nxt),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.out_data  (result.data),
		.can_load  (can_load)
	);

endmodule

// File: sim/tb.sv
// Testbench for time_of_day_counter_bcd_12_24_core: ticks one-second words in and
// checks every time word against a cycle-free predictor in a scoreboard class.
// Depends on todc_pkg, todc_chan_if and the RTL of the counter.
module tb;
	import todc_pkg::*;

	class todc_scoreboard;
		time_t       wall;
		logic        frozen;
		result_t     awaited_q[$];
		int unsigned mismatches;

		function new();
			wall = '0;
			wall.hour12_count = 4'(HalfDay);
			wall.h12_ones = 4'd2;
			wall.h12_tens = 1'b1;
			frozen = 1'b0;
			mismatches = 0;
		endfunction

		function void set_paused(logic p);
			frozen = p;
		endfunction

		function int unsigned pending();
			return awaited_q.size();
		endfunction

		function bit step_base60(inout logic [5:0] bin, inout logic [3:0] ones,
				inout logic [2:0] tens);
			bit wrapped;
			bin = bin + 6'd1;
			wrapped = (bin >= 6'(SecPerMin));
			if (wrapped)
				bin = '0;
			ones = ones + 4'd1;
			if (ones >= 4'(DecRadix)) begin
				ones = '0;
				tens = tens + 3'd1;
				if (tens >= 3'(TensLimit))
					tens = '0;
			end
			return wrapped;
		endfunction

		function void step_hours();
			wall.hour24_count = wall.hour24_count + 5'd1;
			if (wall.hour24_count >= 5'(HoursPerDay))
				wall.hour24_count = '0;
			if (wall.hour24_count == 5'd0) begin
				wall.hour12_count = 4'(HalfDay);
				wall.pm_state = 1'b0;
			end else if (wall.hour24_count == 5'(HalfDay)) begin
				wall.hour12_count = 4'(HalfDay);
				wall.pm_state = 1'b1;
			end else if (wall.hour24_count > 5'(HalfDay)) begin
				wall.hour12_count = 4'(wall.hour24_count - 5'(HalfDay));
				wall.pm_state = 1'b1;
			end else begin
				wall.hour12_count = wall.hour24_count[3:0];
				wall.pm_state = 1'b0;
			end

			if (wall.h12_tens == 1'b1 && wall.h12_ones >= 4'd2) begin
				wall.h12_tens = 1'b0;
				wall.h12_ones = 4'd1;
			end else begin
				wall.h12_ones = wall.h12_ones + 4'd1;
				if (wall.h12_ones >= 4'(DecRadix)) begin
					wall.h12_ones = '0;
					wall.h12_tens = wall.h12_tens + 1'b1;
				end
			end

			wall.h24_ones = wall.h24_ones + 4'd1;
			if (wall.h24_ones >= 4'(DecRadix)) begin
				wall.h24_ones = '0;
				wall.h24_tens = wall.h24_tens + 2'd1;
			end
			if (wall.h24_tens >= 2'd2 && wall.h24_ones >= 4'd4) begin
				wall.h24_tens = '0;
				wall.h24_ones = '0;
			end
		endfunction

		function void note_word(logic tick);
			result_t r;
			if (tick && !frozen) begin
				if (step_base60(wall.sec_count, wall.sec_ones, wall.sec_tens)) begin
					if (step_base60(wall.min_count, wall.min_ones, wall.min_tens))
						step_hours();
				end
			end
			r.seconds_bin  = wall.sec_count;
			r.minutes_bin  = wall.min_count;
			r.hours_24_bin = wall.hour24_count;
			r.hours_12_bin = wall.hour12_count;
			r.pm_flag      = wall.pm_state;
			r.seconds_bcd  = {wall.sec_tens, wall.sec_ones};
			r.minutes_bcd  = {wall.min_tens, wall.min_ones};
			r.hours_12_bcd = {wall.h12_tens, wall.h12_ones};
			r.hours_24_bcd = {wall.h24_tens, wall.h24_ones};
			awaited_q.push_back(r);
		endfunction

		function string show(result_t r);
			return $sformatf("%0d:%0d:%0d h12 %0d pm %0d bcd %h:%h h12 %h h24 %h",
				r.hours_24_bin, r.minutes_bin, r.seconds_bin, r.hours_12_bin, r.pm_flag,
				r.minutes_bcd, r.seconds_bcd, r.hours_12_bcd, r.hours_24_bcd);
		endfunction

		function void check_word(result_t got);
			result_t exp;
			string   bad;
			if (awaited_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("time word with nothing pending: got %s", show(got));
				return;
			end
			exp = awaited_q.pop_front();
			bad = "";
			if (got.seconds_bin !== exp.seconds_bin)   bad = {bad, " seconds_bin"};
			if (got.minutes_bin !== exp.minutes_bin)   bad = {bad, " minutes_bin"};
			if (got.hours_24_bin !== exp.hours_24_bin) bad = {bad, " hours_24_bin"};
			if (got.hours_12_bin !== exp.hours_12_bin) bad = {bad, " hours_12_bin"};
			if (got.pm_flag !== exp.pm_flag)           bad = {bad, " pm_flag"};
			if (got.seconds_bcd !== exp.seconds_bcd)   bad = {bad, " seconds_bcd"};
			if (got.minutes_bcd !== exp.minutes_bcd)   bad = {bad, " minutes_bcd"};
			if (got.hours_12_bcd !== exp.hours_12_bcd) bad = {bad, " hours_12_bcd"};
			if (got.hours_24_bcd !== exp.hours_24_bcd) bad = {bad, " hours_24_bcd"};
			if (bad != "") begin
				mismatches++;
				if (mismatches <= 10)
					$display("time word mismatch in%s: expected %s, got %s", bad,
						show(exp), show(got));
			end
		endfunction
	endclass

	localparam int unsigned QuietLimit = 3000;
	localparam int unsigned HoldCycles = 80;

	logic clk;
	logic arst_n;

	todc_chan_if #(.payload_t(item_t))   item_ch ();
	todc_chan_if #(.payload_t(cfg_t))    cfg_ch ();
	todc_chan_if #(.payload_t(result_t)) result_ch ();

	time_of_day_counter_bcd_12_24_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.cfg(cfg_ch),
		.result(result_ch)
	);

	todc_scoreboard sb;
	int unsigned    tx_idle_pct;
	int unsigned    rx_stall_pct;
	bit             long_hold;
	int unsigned    quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		result_ch.ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				result_ch.ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				long_hold = 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				sb.set_paused(cfg_ch.data.paused);
			if (item_ch.valid && item_ch.ready)
				sb.note_word(item_ch.data.tick);
			if (result_ch.valid && result_ch.ready)
				sb.check_word(result_ch.data);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cfg_ch.valid && cfg_ch.ready) || (item_ch.valid && item_ch.ready) ||
					(result_ch.valid && result_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QuietLimit) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic send_word(input logic tick);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data.tick <= tick;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_paused(input logic p);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data.paused <= p;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
			input bit with_hold);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		write_paused(1'b0);
		for (int i = 0; i < 350; i++) begin
			if (with_hold && i == 100)
				long_hold = 1'b1;
			if (i == 200)
				drain();
			send_word($urandom_range(99) < 85);
		end
		drain();
		write_paused(1'b1);
		for (int i = 0; i < 75; i++)
			send_word($urandom_range(99) < 85);
		drain();
	endtask

	initial begin
		sb = new();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		long_hold = 1'b0;
		quiet_cycles = 0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// read at reset, tick, ticks and reads while paused
		send_word(1'b0);
		send_word(1'b1);
		send_word(1'b1);
		send_word(1'b0);
		drain();
		write_paused(1'b1);
		send_word(1'b1);
		send_word(1'b1);
		send_word(1'b0);
		send_word(1'b1);
		drain();
		write_paused(1'b0);
		send_word(1'b1);
		send_word(1'b0);
		send_word(1'b1);
		drain();

		run_phase(0, 0, 1'b1);
		run_phase(63, 0, 1'b0);
		run_phase(0, 63, 1'b0);
		run_phase(37, 37, 1'b0);

		drain();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
